### src/pfc_pkg.sv
`default_nettype none

package pfc_pkg;

    // Layout codes of the source_format and target_format registers.
    localparam logic [3:0] FMT_RGBA  = 4'd0;
    localparam logic [3:0] FMT_ARGB  = 4'd1;
    localparam logic [3:0] FMT_BGRA  = 4'd2;
    localparam logic [3:0] FMT_ABGR  = 4'd3;
    localparam logic [3:0] FMT_RGBX  = 4'd4;
    localparam logic [3:0] FMT_XRGB  = 4'd5;
    localparam logic [3:0] FMT_BGRX  = 4'd6;
    localparam logic [3:0] FMT_XBGR  = 4'd7;
    localparam logic [3:0] FMT_RGB   = 4'd8;
    localparam logic [3:0] FMT_BGR   = 4'd9;
    localparam logic [3:0] FMT_ALPHA = 4'd10;
    localparam logic [3:0] FMT_GRAY  = 4'd11;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SOURCE_FORMAT      = 2'd0;
    localparam logic [1:0] CFG_TARGET_FORMAT      = 2'd1;
    localparam logic [1:0] CFG_REFUSE_SAME_FORMAT = 2'd2;

    localparam logic [7:0] FILL_BYTE = 8'hFF;

    localparam logic [2:0] COUNT_NONE = 3'd0;
    localparam logic [2:0] COUNT_ONE  = 3'd1;
    localparam logic [2:0] COUNT_RGB  = 3'd3;
    localparam logic [2:0] COUNT_FOUR = 3'd4;

    // Color channels of one pixel in layout-independent form.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pfc_chan_t;

    // One converted pixel.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [2:0] count;
        logic       ok;
    } pfc_pixel_t;

endpackage

`default_nettype wire

### src/pixel_format_converter.sv
// A pixel accepted into the input registers is converted combinationally and
// captured in the result registers that drive the result ports, with done high
// for exactly one cycle.
// Throughput: one pixel per cycle; busy is always low, set by the input and
// result registers with only byte muxing between them.
// Reset (rst_n low, asynchronous) clears the configuration registers to zero
// and drops pending beats; the receiver cannot stall the result.
`default_nettype none

module pixel_format_converter
    import pfc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic [1:0] cfg_index,
    input  wire logic [3:0] cfg_data,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [7:0] in_byte0,
    input  wire logic [7:0] in_byte1,
    input  wire logic [7:0] in_byte2,
    input  wire logic [7:0] in_byte3,
    input  wire logic       last_pixel,
    output logic            done,
    output logic [7:0]      out_byte0,
    output logic [7:0]      out_byte1,
    output logic [7:0]      out_byte2,
    output logic [7:0]      out_byte3,
    output logic [2:0]      byte_count,
    output logic            ok,
    output logic            last_out
);

    logic [3:0] source_format_reg;
    logic [3:0] target_format_reg;
    logic       refuse_same_format_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte0_reg;
    logic [7:0] in_byte1_reg;
    logic [7:0] in_byte2_reg;
    logic [7:0] in_byte3_reg;
    logic       in_last_reg;

    logic       out_valid_reg;
    pfc_pixel_t out_pixel_reg;
    logic       out_last_reg;

    pfc_chan_t  chan;
    pfc_pixel_t out_pixel_next;
    logic       accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg      <= FMT_RGBA;
            target_format_reg      <= FMT_RGBA;
            refuse_same_format_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SOURCE_FORMAT:      source_format_reg      <= cfg_data;
                CFG_TARGET_FORMAT:      target_format_reg      <= cfg_data;
                CFG_REFUSE_SAME_FORMAT: refuse_same_format_reg <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= accept;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte0_reg <= in_byte0;
            in_byte1_reg <= in_byte1;
            in_byte2_reg <= in_byte2;
            in_byte3_reg <= in_byte3;
            in_last_reg  <= last_pixel;
        end
        if (in_valid_reg)
        begin
            out_pixel_reg <= out_pixel_next;
            out_last_reg  <= in_last_reg;
        end
    end

    pfc_unpack u_unpack (
        .src_format (source_format_reg),
        .byte0      (in_byte0_reg),
        .byte1      (in_byte1_reg),
        .byte2      (in_byte2_reg),
        .byte3      (in_byte3_reg),
        .chan       (chan)
    );

    pfc_pack u_pack (
        .src_format  (source_format_reg),
        .dst_format  (target_format_reg),
        .refuse_same (refuse_same_format_reg),
        .chan        (chan),
        .pixel       (out_pixel_next)
    );

    assign done       = out_valid_reg;
    assign out_byte0  = out_pixel_reg.byte0;
    assign out_byte1  = out_pixel_reg.byte1;
    assign out_byte2  = out_pixel_reg.byte2;
    assign out_byte3  = out_pixel_reg.byte3;
    assign byte_count = out_pixel_reg.count;
    assign ok         = out_pixel_reg.ok;
    assign last_out   = out_last_reg;

endmodule

`default_nettype wire

### src/pfc_unpack.sv
`default_nettype none

module pfc_unpack
    import pfc_pkg::*;
(
    input  wire logic [3:0] src_format,
    input  wire logic [7:0] byte0,
    input  wire logic [7:0] byte1,
    input  wire logic [7:0] byte2,
    input  wire logic [7:0] byte3,
    output pfc_chan_t       chan
);

    logic       left;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;

    // Four-byte layouts keep color in bytes 0..2 (even codes) or 1..3 (odd codes).
    assign left = ~src_format[0];
    assign c0   = left ? byte0 : byte1;
    assign c1   = left ? byte1 : byte2;
    assign c2   = left ? byte2 : byte3;

    always_comb
    begin
        chan.alpha = FILL_BYTE;
        case (src_format) inside
            [FMT_RGBA:FMT_XBGR]:
            begin
                chan.green = c1;
                chan.red   = src_format[1] ? c2 : c0;
                chan.blue  = src_format[1] ? c0 : c2;
                chan.alpha = left ? byte3 : byte0;
            end
            FMT_RGB:
            begin
                chan.red   = byte0;
                chan.green = byte1;
                chan.blue  = byte2;
            end
            FMT_BGR:
            begin
                chan.red   = byte2;
                chan.green = byte1;
                chan.blue  = byte0;
            end
            default:
            begin
                // Single-byte sources (and invalid codes, which fail later).
                chan.red   = byte0;
                chan.green = byte0;
                chan.blue  = byte0;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/pfc_pack.sv
`default_nettype none

module pfc_pack
    import pfc_pkg::*;
(
    input  wire logic [3:0] src_format,
    input  wire logic [3:0] dst_format,
    input  wire logic       refuse_same,
    input  wire pfc_chan_t  chan,
    output pfc_pixel_t      pixel
);

    logic       good;
    logic       left;
    logic [7:0] fourth;
    logic [7:0] c0;
    logic [7:0] c2;

    assign good = !(refuse_same && (src_format == dst_format))
               && (src_format <= FMT_GRAY) && (dst_format <= FMT_GRAY);

    assign left = ~dst_format[0];
    assign c0   = dst_format[1] ? chan.blue : chan.red;
    assign c2   = dst_format[1] ? chan.red : chan.blue;

    // Alpha (or X) is carried only from a four-byte source into the same layout
    // or between two layouts with real alpha.
    always_comb
    begin
        fourth = FILL_BYTE;
        if (!src_format[3] && ((src_format == dst_format)
                || (src_format <= FMT_ABGR && dst_format <= FMT_ABGR)))
        begin
            fourth = chan.alpha;
        end
    end

    always_comb
    begin
        pixel.byte0 = 8'd0;
        pixel.byte1 = 8'd0;
        pixel.byte2 = 8'd0;
        pixel.byte3 = 8'd0;
        pixel.count = COUNT_NONE;
        pixel.ok    = 1'b0;
        if (good)
        begin
            pixel.ok = 1'b1;
            case (dst_format) inside
                [FMT_RGBA:FMT_XBGR]:
                begin
                    pixel.count = COUNT_FOUR;
                    if (left)
                    begin
                        pixel.byte0 = c0;
                        pixel.byte1 = chan.green;
                        pixel.byte2 = c2;
                        pixel.byte3 = fourth;
                    end
                    else
                    begin
                        pixel.byte0 = fourth;
                        pixel.byte1 = c0;
                        pixel.byte2 = chan.green;
                        pixel.byte3 = c2;
                    end
                end
                FMT_RGB:
                begin
                    pixel.count = COUNT_RGB;
                    pixel.byte0 = chan.red;
                    pixel.byte1 = chan.green;
                    pixel.byte2 = chan.blue;
                end
                FMT_BGR:
                begin
                    pixel.count = COUNT_RGB;
                    pixel.byte0 = chan.blue;
                    pixel.byte1 = chan.green;
                    pixel.byte2 = chan.red;
                end
                default:
                begin
                    pixel.count = COUNT_ONE;
                    pixel.byte0 = chan.red;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
